// ===== rtl/bsmv_pkg.sv =====
package bsmv_pkg;

    // Fixed field widths of the stream items.
    localparam int IDX_W       = 12;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 64;
    localparam int ROW_W       = 16;
    localparam int OUT_LANES   = 8;

    // Packed payload widths, padded to whole bytes.
    localparam int S_FIELDS_W  = IDX_W + VAL_W + OUT_LANES * VAL_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = OUT_LANES * SUM_W + ROW_W;
    localparam int LANE_LSB    = IDX_W + VAL_W;

    // Defaults for the top level parameters.
    localparam int DEF_LANES        = 8;
    localparam int DEF_VECTOR_DEPTH = 4096;

    // Item kinds carried in tuser.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } bsmv_op_t;

    // Per-cycle controls of a lane multiply-accumulate unit.
    typedef struct packed {
        logic load;     // capture the lane value of an accepted multiply item
        logic mul;      // form the product with the fetched vector entry
        logic acc_en;   // fold the product into the accumulator
        logic clear;    // the folded item closes the row: clear instead of storing
    } bsmv_lane_ctl_t;

endpackage

// ===== rtl/bsmv_vec_mem.sv =====
module bsmv_vec_mem
    import bsmv_pkg::*;
#(
    parameter int DEPTH  = DEF_VECTOR_DEPTH,
    parameter int ADDR_W = $clog2(DEF_VECTOR_DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [VAL_W-1:0]  wdata,
    output logic [VAL_W-1:0]  rdata
);

    logic [VAL_W-1:0] mem_reg [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    // Single port store: a write or a registered read per cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bsmv_lane.sv =====
module bsmv_lane
    import bsmv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bsmv_lane_ctl_t        ctl,
    input  logic [VAL_W-1:0]      a_in,
    input  logic [VAL_W-1:0]      x_in,
    output logic [SUM_W-1:0]      sum_next
);

    logic [VAL_W-1:0] a_reg;
    logic [SUM_W-1:0] prod_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] raw_sum;
    logic             ovf;

    // Matrix value of this lane, then the exact Q32.32 product.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_reg <= a_in;
        end
        if (ctl.mul) begin
            prod_reg <= SUM_W'($signed(a_reg) * $signed(x_in));
        end
    end

    // Saturating add of the product onto the running sum.
    always_comb begin
        raw_sum = acc_reg + prod_reg;
        ovf     = (acc_reg[SUM_W-1] == prod_reg[SUM_W-1]) &&
                  (raw_sum[SUM_W-1] != acc_reg[SUM_W-1]);
        if (ovf) begin
            sum_next = acc_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = raw_sum;
        end
    end

    // Accumulator; the row-closing item leaves it cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= ctl.clear ? '0 : sum_next;
        end
    end

endmodule

// ===== rtl/block_sparse_matvec_accumulator_top.sv =====
// Path: a multiply item that closes a row passes the vector store read at its
// transfer, the product register, then accumulation into the output register,
// where its result shows on m_tvalid.
// Throughput: one item per cycle; the input stalls only while a finished row
// waits in the output register and the next closing item reaches accumulation.
// Reset clears the pipeline, the lane accumulators and the row counter; the
// vector store is not cleared and holds nothing valid until loaded.
module block_sparse_matvec_accumulator_top
    import bsmv_pkg::*;
#(
    parameter int LANES        = DEF_LANES,
    parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vec_index[11:0], x_value[43:12], lane_value_0..7 [75:44] .. [299:268], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // last_of_row
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_sum_0..7 [63:0] .. [511:448], block_row[527:512]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int NLANES = (LANES < OUT_LANES) ? LANES : OUT_LANES;

    logic [IDX_W-1:0]        s_idx;
    logic [VAL_W-1:0]        s_x;
    logic [IDX_W+ADDR_W-1:0] idx_ext;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    in_range;
    logic                    accept;
    logic                    is_mul;
    logic [VAL_W-1:0]        mem_rdata;
    logic [VAL_W-1:0]        x_fetch;

    logic s1_valid_reg, s1_last_reg, s1_inrange_reg;
    logic s2_valid_reg, s2_last_reg;
    logic stall, adv1, adv2, emit;

    bsmv_lane_ctl_t   lane_ctl;
    logic [SUM_W-1:0] sum_next [OUT_LANES];

    logic             m_tvalid_reg;
    logic [SUM_W-1:0] row_sum_reg [OUT_LANES];
    logic [ROW_W-1:0] block_row_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    // Input decode and vector store addressing.
    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s_x      = s_tdata[IDX_W +: VAL_W];
    assign idx_ext  = {{ADDR_W{1'b0}}, s_idx};
    assign mem_addr = idx_ext[ADDR_W-1:0];
    assign in_range = 32'(s_idx) < 32'(VECTOR_DEPTH);
    assign is_mul   = (bsmv_op_t'(s_tuser) == OP_MUL);
    assign accept   = s_tvalid && s_tready;

    // Pipeline flow: only a row-closing item blocked by a full output register stalls.
    assign emit     = s2_valid_reg && s2_last_reg;
    assign stall    = emit && m_tvalid_reg && !m_tready;
    assign adv2     = s2_valid_reg && !stall;
    assign adv1     = s1_valid_reg && (!s2_valid_reg || adv2);
    assign s_tready = !s1_valid_reg || adv1;

    bsmv_vec_mem #(
        .DEPTH  (VECTOR_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_vec_mem (
        .aclk  (aclk),
        .en    (accept && in_range),
        .we    (!is_mul),
        .addr  (mem_addr),
        .wdata (s_x),
        .rdata (mem_rdata)
    );

    // An index beyond the store reads as zero.
    assign x_fetch = s1_inrange_reg ? mem_rdata : '0;

    always_comb begin
        lane_ctl.load   = accept && is_mul;
        lane_ctl.mul    = adv1;
        lane_ctl.acc_en = adv2;
        lane_ctl.clear  = s2_last_reg;
    end

    // Lane units below the configured count; the others report zero.
    for (genvar k = 0; k < OUT_LANES; k++) begin : g_lane
        if (k < NLANES) begin : g_act
            bsmv_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (lane_ctl),
                .a_in     (s_tdata[LANE_LSB + k*VAL_W +: VAL_W]),
                .x_in     (x_fetch),
                .sum_next (sum_next[k])
            );
        end else begin : g_off
            assign sum_next[k] = '0;
        end
    end

    // Stage valids and item tags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= is_mul;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv1) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_mul) begin
            s1_last_reg    <= s_tlast;
            s1_inrange_reg <= in_range;
        end
        if (adv1) begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // Output register and block row counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            row_cnt_reg  <= '0;
        end else begin
            if (adv2 && emit) begin
                m_tvalid_reg <= 1'b1;
                row_cnt_reg  <= row_cnt_reg + 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && emit) begin
            for (int k = 0; k < OUT_LANES; k++) begin
                row_sum_reg[k] <= sum_next[k];
            end
            block_row_reg <= row_cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    for (genvar k = 0; k < OUT_LANES; k++) begin : g_pack
        assign m_tdata[k*SUM_W +: SUM_W] = row_sum_reg[k];
    end
    assign m_tdata[OUT_LANES*SUM_W +: ROW_W] = block_row_reg;

    // Each finished row advances the row counter by exactly one.
    a_row_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && emit) |=> (row_cnt_reg == $past(row_cnt_reg) + 1'b1))
        else $error("row counter did not advance on a finished row");

    // A held accumulate stage keeps its item.
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !adv2) |=> (s2_valid_reg && $stable(s2_last_reg)))
        else $error("accumulate stage lost a stalled item");

    // A waiting result is never overwritten by the next finished row.
    a_out_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !(adv2 && emit))
        else $error("result overwritten before transfer");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bsmv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int          RAND_ITEMS  = 800;
    localparam int          END_CYCLES  = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] Q_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] Q_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] Q_ONE   = 32'h0001_0000;

    typedef logic [OUT_LANES-1:0][VAL_W-1:0] lane_vals_t;

    // One column or load transfer; hold_off makes the sender wait for all rows first.
    typedef struct packed {
        bsmv_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] x;
        lane_vals_t       lanes;
        logic             last;
        logic             hold_off;
    } column_t;

    typedef struct packed {
        logic [OUT_LANES-1:0][SUM_W-1:0] sum;
        logic [ROW_W-1:0]                row;
    } row_sums_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    block_sparse_matvec_accumulator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pending transfers and the rows they are expected to produce.
    column_t   column_queue[$];
    row_sums_t rows_due[$];

    // Predictor state: vector copy, lane sums and row number.
    logic [VAL_W-1:0] x_copy [DEF_VECTOR_DEPTH];
    logic [SUM_W-1:0] lane_sum [OUT_LANES];
    logic [ROW_W-1:0] row_num = '0;

    // Generator bookkeeping, so that multiplies only read loaded entries.
    bit               gen_loaded [DEF_VECTOR_DEPTH];
    int               loaded_list[$];
    bit               pause_next = 0;

    int          error_count = 0;
    int unsigned cycle_count = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
            s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    // Applies one accepted transfer to the predictor state.
    task automatic predict_column(input column_t c);
        logic signed [SUM_W-1:0] xv;
        logic signed [SUM_W-1:0] av;
        logic signed [SUM_W-1:0] prod;
        row_sums_t               r;
        if (c.op == OP_LOAD) begin
            if (c.idx < DEF_VECTOR_DEPTH) x_copy[c.idx] = c.x;
        end else begin
            xv = '0;
            if (c.idx < DEF_VECTOR_DEPTH) xv = {{VAL_W{x_copy[c.idx][VAL_W-1]}}, x_copy[c.idx]};
            for (int k = 0; k < OUT_LANES && k < DEF_LANES; k++) begin
                av = {{VAL_W{c.lanes[k][VAL_W-1]}}, c.lanes[k]};
                prod = av * xv;
                lane_sum[k] = sat_add(lane_sum[k], prod);
            end
            if (c.last) begin
                for (int k = 0; k < OUT_LANES; k++) begin
                    r.sum[k] = (k < DEF_LANES) ? lane_sum[k] : '0;
                    lane_sum[k] = '0;
                end
                r.row = row_num;
                rows_due.push_back(r);
                row_num = row_num + 1'b1;
            end
        end
    endtask

    function automatic void add_item(input bsmv_op_t op, input logic [IDX_W-1:0] idx,
                                     input logic [VAL_W-1:0] x, input lane_vals_t lanes,
                                     input logic last);
        column_t c;
        c.op       = op;
        c.idx      = idx;
        c.x        = x;
        c.lanes    = lanes;
        c.last     = last;
        c.hold_off = pause_next;
        pause_next = 0;
        column_queue.push_back(c);
        if (op == OP_LOAD && !gen_loaded[idx]) begin
            gen_loaded[idx] = 1;
            loaded_list.push_back(int'(idx));
        end
    endfunction

    // Values lean toward the extremes so that saturation shows up often.
    function automatic logic [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return VAL_W'($signed($urandom_range(0, 2 * Q_ONE)) - $signed(Q_ONE));
            default: return $urandom;
        endcase
    endfunction

    function automatic lane_vals_t rand_lanes();
        lane_vals_t v;
        for (int k = 0; k < OUT_LANES; k++) v[k] = rand_val();
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] pick_loaded();
        return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    // Sender bookkeeping: a transfer seen at the rising edge frees the slot.
    column_t cur_item;
    bit      item_taken = 0;
    int      burst_left = 1;
    int      gap_left   = 0;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_column(cur_item);
            item_taken = 1;
        end
    end

    // Driver: bursts of transfers with random gaps, changing on the falling edge.
    always @(negedge aclk) begin : driver
        logic [S_TDATA_W-1:0] word;
        if (aresetn) begin
            if (!s_tvalid || item_taken) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (column_queue.size() != 0 &&
                             !(column_queue[0].hold_off && rows_due.size() != 0)) begin
                    cur_item = column_queue.pop_front();
                    word = '0;
                    word[0 +: IDX_W] = cur_item.idx;
                    word[IDX_W +: VAL_W] = cur_item.x;
                    word[LANE_LSB +: OUT_LANES * VAL_W] = cur_item.lanes;
                    s_tdata  <= word;
                    s_tlast  <= cur_item.last;
                    s_tuser  <= cur_item.op;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            item_taken = 0;
        end
    end

    // Receiver: stall pattern whose density changes periodically.
    rx_mode_t rx_mode    = RX_OPEN;
    int       stall_left = 0;
    int       rx_phase   = 0;

    always @(negedge aclk) begin : receiver
        logic rdy;
        if (aresetn) begin
            rx_phase++;
            if (rx_phase % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
            rdy = 1'b1;
            if (stall_left != 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (rx_mode == RX_LIGHT && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                rdy = 1'b0;
            end else if (rx_mode == RX_HEAVY && $urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(0, 15);
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    // Monitor: every row transfer is checked against the oldest expected row.
    always @(posedge aclk) begin : monitor
        row_sums_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("row result with none expected, block_row %0d",
                                          m_tdata[OUT_LANES*SUM_W +: ROW_W]));
            end else begin
                exp = rows_due.pop_front();
                for (int k = 0; k < OUT_LANES; k++) begin
                    if (m_tdata[k*SUM_W +: SUM_W] !== exp.sum[k]) begin
                        report_mismatch($sformatf("row %0d row_sum_%0d got %h expected %h",
                                                  exp.row, k, m_tdata[k*SUM_W +: SUM_W],
                                                  exp.sum[k]));
                    end
                end
                if (m_tdata[OUT_LANES*SUM_W +: ROW_W] !== exp.row) begin
                    report_mismatch($sformatf("block_row got %0d expected %0d",
                                              m_tdata[OUT_LANES*SUM_W +: ROW_W], exp.row));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        lane_vals_t alt;
        lane_vals_t mixed;
        int         start_size;
        int         next_pause;
        int         kind;
        int         cols;

        for (int k = 0; k < OUT_LANES; k++) begin
            lane_sum[k] = '0;
            alt[k] = k[0] ? Q_MAX : Q_MIN;
        end
        mixed = {Q_ONE + (Q_ONE >> 1), 32'h0, 32'hFFFF_FFFF, 32'h1, Q_MIN, Q_MAX,
                 32'hFFFF_0000, Q_ONE};

        // Directed part: vector extremes, ignored load fields, saturation both ways,
        // recovery from a clamped sum, an empty block row and overwritten entries.
        add_item(OP_LOAD, 12'd0, Q_MAX, '0, 1'b0);
        add_item(OP_LOAD, 12'hFFF, Q_MIN, '0, 1'b0);
        add_item(OP_LOAD, 12'd1, Q_ONE, '0, 1'b0);
        add_item(OP_LOAD, 12'd2, 32'hFFFF_FFFF, '0, 1'b0);
        add_item(OP_LOAD, 12'd3, 32'h0, '0, 1'b0);
        add_item(OP_LOAD, 12'd5, rand_val(), rand_lanes(), 1'b1);
        add_item(OP_MUL, 12'hFFF, $urandom, alt, 1'b0);
        add_item(OP_MUL, 12'hFFF, $urandom, alt, 1'b0);
        add_item(OP_MUL, 12'd0, $urandom, {OUT_LANES{Q_MIN}}, 1'b1);
        pause_next = 1;
        add_item(OP_MUL, 12'd0, 32'h0, '0, 1'b1);
        add_item(OP_MUL, 12'd1, 32'h0, mixed, 1'b0);
        add_item(OP_MUL, 12'd2, 32'h0, mixed, 1'b0);
        add_item(OP_MUL, 12'd3, $urandom, rand_lanes(), 1'b1);
        add_item(OP_LOAD, 12'd1, Q_MAX, rand_lanes(), 1'b1);
        add_item(OP_MUL, 12'd1, $urandom, {OUT_LANES{Q_MIN}}, 1'b0);
        add_item(OP_MUL, 12'd5, $urandom, rand_lanes(), 1'b1);
        add_item(OP_MUL, 12'hFFF, $urandom, {OUT_LANES{Q_MAX}}, 1'b1);
        add_item(OP_MUL, 12'd0, $urandom, {OUT_LANES{Q_MAX}}, 1'b1);

        // Random part: mostly whole block rows, with load bursts and loads mid-row.
        pause_next = 1;
        start_size = column_queue.size();
        next_pause = 150;
        while (column_queue.size() - start_size < RAND_ITEMS) begin
            if (column_queue.size() - start_size >= next_pause) begin
                pause_next = 1;
                next_pause += 150;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                repeat ($urandom_range(1, 4)) begin
                    add_item(OP_LOAD, IDX_W'($urandom), rand_val(), rand_lanes(),
                             1'($urandom));
                end
            end else if (kind == 3) begin
                add_item(OP_MUL, 12'd0, 32'h0, '0, 1'b1);
            end else begin
                cols = $urandom_range(1, 6);
                for (int c = 0; c < cols; c++) begin
                    if (kind == 4 && $urandom_range(0, 1) == 1) begin
                        add_item(OP_LOAD, IDX_W'($urandom), rand_val(), rand_lanes(),
                                 1'($urandom));
                    end
                    add_item(OP_MUL, pick_loaded(), $urandom, rand_lanes(), c == cols - 1);
                end
            end
        end

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the last transfer, then for the last row and a few quiet cycles.
        while (column_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
